/* rtl/core/tcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, rotor and reflector tables and letter arithmetic for the
// three-rotor cipher machine. No dependencies.
package tcm_pkg;

  typedef logic [4:0]  letter_t;
  typedef logic [2:0]  rotor_num_t;
  typedef logic [2:0]  rotor_sel_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [19:0] plug_word_t;

  localparam cfg_idx_t CFG_LEFT_ROTOR   = 3'd0;
  localparam cfg_idx_t CFG_MIDDLE_ROTOR = 3'd1;
  localparam cfg_idx_t CFG_RIGHT_ROTOR  = 3'd2;
  localparam cfg_idx_t CFG_PLUG_PAIRS_A = 3'd3;
  localparam cfg_idx_t CFG_PLUG_PAIRS_B = 3'd4;
  localparam cfg_idx_t CFG_PLUG_PAIRS_C = 3'd5;

  localparam rotor_num_t LEFT_ROTOR_RST   = 3'd1;
  localparam rotor_num_t MIDDLE_ROTOR_RST = 3'd2;
  localparam rotor_num_t RIGHT_ROTOR_RST  = 3'd3;

  localparam letter_t LETTER_A   = 5'd0;
  localparam letter_t LETTER_Z   = 5'd25;
  localparam letter_t NLET       = 5'd26;

  typedef struct packed {
    logic    command;
    letter_t in_letter;
    letter_t new_left;
    letter_t new_middle;
    letter_t new_right;
  } in_req_t;

  typedef struct packed {
    letter_t out_letter;
    letter_t out_left;
    letter_t out_middle;
    letter_t out_right;
  } out_res_t;

  typedef struct packed {
    plug_word_t pairs_c;
    plug_word_t pairs_b;
    plug_word_t pairs_a;
  } plug_cfg_t;

  typedef struct packed {
    letter_t left;
    letter_t middle;
    letter_t right;
  } rotor_pos_t;

  localparam logic CMD_ENCIPHER = 1'b0;
  localparam logic CMD_LOAD     = 1'b1;

  typedef logic [8*26-1:0]      wiring_str_t;
  typedef wiring_str_t [4:0]    wiring_set_t;
  typedef letter_t [25:0]       row_t;
  typedef row_t [4:0]           tab_t;

  localparam wiring_set_t WIRE_SET = {
    wiring_str_t'("VZBRGITYUPSDNHLXAWMJQOFECK"),
    wiring_str_t'("ESOVPZJAYQUIRHXLNFTGKDCMWB"),
    wiring_str_t'("BDFHJLCPRTXVZNYEIWGAKMUSQO"),
    wiring_str_t'("AJDKSIRUXBLHWTMCQGZNPYFVOE"),
    wiring_str_t'("EKMFLGDQVZNTOWYHXUSPAIBRCJ")
  };
  localparam wiring_str_t REFL_STR = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

  localparam letter_t [4:0] NOTCH_TAB = {5'd25, 5'd9, 5'd21, 5'd4, 5'd16};

  function automatic letter_t char_at(wiring_str_t s, int j);
    logic [7:0] ch;
    ch = s[8*(25-j) +: 8];
    return letter_t'(ch - 8'd65);
  endfunction

  function automatic tab_t build_fwd();
    tab_t t;
    for (int s = 0; s < 5; s++) begin
      for (int j = 0; j < 26; j++) begin
        t[s][j] = char_at(WIRE_SET[s], j);
      end
    end
    return t;
  endfunction

  function automatic tab_t build_inv();
    tab_t f;
    tab_t t;
    f = build_fwd();
    t = '0;
    for (int s = 0; s < 5; s++) begin
      for (int j = 0; j < 26; j++) begin
        t[s][f[s][j]] = letter_t'(j);
      end
    end
    return t;
  endfunction

  function automatic row_t build_refl();
    row_t r;
    for (int j = 0; j < 26; j++) begin
      r[j] = char_at(REFL_STR, j);
    end
    return r;
  endfunction

  localparam tab_t FWD_TAB  = build_fwd();
  localparam tab_t INV_TAB  = build_inv();
  localparam row_t REFL_TAB = build_refl();

  function automatic rotor_sel_t sel_of(rotor_num_t n);
    if (n >= 3'd1 && n <= 3'd5) begin
      return rotor_sel_t'(n - 3'd1);
    end
    return '0;
  endfunction

  function automatic letter_t mod26(letter_t x);
    return (x >= NLET) ? letter_t'(x - NLET) : x;
  endfunction

  function automatic letter_t inc26(letter_t x);
    return (x == LETTER_Z) ? LETTER_A : letter_t'(x + 5'd1);
  endfunction

  function automatic letter_t add26(letter_t x, letter_t p);
    logic [5:0] s;
    s = {1'b0, x} + {1'b0, p};
    if (s >= {1'b0, NLET}) begin
      s = s - {1'b0, NLET};
    end
    return s[4:0];
  endfunction

  function automatic letter_t sub26(letter_t y, letter_t p);
    logic [5:0] d;
    d = {1'b0, y} - {1'b0, p};
    if (y < p) begin
      d = d + {1'b0, NLET};
    end
    return d[4:0];
  endfunction

  function automatic letter_t pass_fwd(rotor_sel_t sel, letter_t pos, letter_t x);
    return sub26(FWD_TAB[sel][add26(x, pos)], pos);
  endfunction

  function automatic letter_t pass_inv(rotor_sel_t sel, letter_t pos, letter_t x);
    return sub26(INV_TAB[sel][add26(x, pos)], pos);
  endfunction

endpackage

/* rtl/core/tcm_plugboard.sv */
`timescale 1ns / 1ps
// Plugboard: resolves the six configured pairs and swaps the letter on the
// way in and on the way out. Depends on tcm_pkg.
module tcm_plugboard (
  input  tcm_pkg::plug_cfg_t cfg,
  input  tcm_pkg::letter_t   fwd_in,
  input  tcm_pkg::letter_t   bwd_in,
  output tcm_pkg::letter_t   fwd_out,
  output tcm_pkg::letter_t   bwd_out
);
  import tcm_pkg::*;

  logic [59:0] words;
  letter_t     pa [6];
  letter_t     pb [6];
  logic [5:0]  applied;

  assign words = cfg;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pa[k] = words[10*k +: 5];
      pb[k] = words[10*k+5 +: 5];
    end
  end

  // A pair counts only if it is well formed and shares no letter with an
  // earlier pair that counts.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      applied[k] = (pa[k] != pb[k]) && (pa[k] < NLET) && (pb[k] < NLET);
      for (int j = 0; j < k; j++) begin
        if (applied[j] && (pa[j] == pa[k] || pa[j] == pb[k] ||
                           pb[j] == pa[k] || pb[j] == pb[k])) begin
          applied[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    fwd_out = fwd_in;
    bwd_out = bwd_in;
    for (int k = 0; k < 6; k++) begin
      if (applied[k]) begin
        if (fwd_in == pa[k]) begin
          fwd_out = pb[k];
        end else if (fwd_in == pb[k]) begin
          fwd_out = pa[k];
        end
        if (bwd_in == pa[k]) begin
          bwd_out = pb[k];
        end else if (bwd_in == pb[k]) begin
          bwd_out = pa[k];
        end
      end
    end
  end

endmodule

/* rtl/core/three_rotor_cipher_machine.sv */
`timescale 1ns / 1ps
// Three-rotor cipher machine with reflector B; depends on tcm_pkg and tcm_plugboard.
// An accepted encipher request passes the s1, s2, s3 and output registers to its result.
// Rotor stepping at the input register lets one request in every cycle unless out_stall stalls.
// A load request updates the positions and yields no result.
// Synchronous reset sets all positions to A, rotors I, II, III and an empty plugboard.
module three_rotor_cipher_machine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcm_pkg::in_req_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcm_pkg::out_res_t    out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tcm_pkg::cfg_idx_t    cfg_index,
  input  tcm_pkg::plug_word_t  cfg_data
);
  import tcm_pkg::*;

  rotor_num_t left_rotor_r, middle_rotor_r, right_rotor_r;
  plug_cfg_t  plug_cfg_r;
  rotor_sel_t sel_l, sel_m, sel_r;

  rotor_pos_t pos_r, pos_nxt, pos_step;
  logic       mid_at, right_at;
  logic       accept;

  logic       v1_r, v2_r, v3_r, v4_r;
  logic       go1, go2, go3, go4;
  rotor_pos_t s1_pos_r, s2_pos_r, s3_pos_r;
  letter_t    s1_let_r, s2_let_r, s3_let_r;
  letter_t    s1_let_r_in;
  letter_t    s2_let_nxt, s3_let_nxt, s4_let_pre;
  letter_t    plug_in_let, plug_out_let;
  out_res_t   out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_rotor_r   <= LEFT_ROTOR_RST;
      middle_rotor_r <= MIDDLE_ROTOR_RST;
      right_rotor_r  <= RIGHT_ROTOR_RST;
      plug_cfg_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT_ROTOR:   left_rotor_r       <= cfg_data[2:0];
        CFG_MIDDLE_ROTOR: middle_rotor_r     <= cfg_data[2:0];
        CFG_RIGHT_ROTOR:  right_rotor_r      <= cfg_data[2:0];
        CFG_PLUG_PAIRS_A: plug_cfg_r.pairs_a <= cfg_data;
        CFG_PLUG_PAIRS_B: plug_cfg_r.pairs_b <= cfg_data;
        CFG_PLUG_PAIRS_C: plug_cfg_r.pairs_c <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sel_l = sel_of(left_rotor_r);
  assign sel_m = sel_of(middle_rotor_r);
  assign sel_r = sel_of(right_rotor_r);

  assign go4 = !v4_r || !out_stall;
  assign go3 = !v3_r || go4;
  assign go2 = !v2_r || go3;
  assign go1 = !v1_r || go2;
  assign in_stall = !go1;
  assign accept = in_valid && go1;

  // Rotor stepping uses the positions before the step for every notch test.
  assign mid_at   = (pos_r.middle == NOTCH_TAB[sel_m]);
  assign right_at = (pos_r.right == NOTCH_TAB[sel_r]);

  always_comb begin
    pos_step.left   = mid_at ? inc26(pos_r.left) : pos_r.left;
    pos_step.middle = (mid_at || right_at) ? inc26(pos_r.middle) : pos_r.middle;
    pos_step.right  = inc26(pos_r.right);
    pos_nxt = pos_r;
    if (accept) begin
      if (in_data.command == CMD_LOAD) begin
        pos_nxt.left   = mod26(in_data.new_left);
        pos_nxt.middle = mod26(in_data.new_middle);
        pos_nxt.right  = mod26(in_data.new_right);
      end else begin
        pos_nxt = pos_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign plug_in_let = mod26(in_data.in_letter);

  tcm_plugboard u_plugboard (
    .cfg     (plug_cfg_r),
    .fwd_in  (plug_in_let),
    .bwd_in  (s4_let_pre),
    .fwd_out (s1_let_r_in),
    .bwd_out (plug_out_let)
  );

  always_comb begin
    letter_t c;
    c = pass_fwd(sel_r, s1_pos_r.right, s1_let_r);
    s2_let_nxt = pass_fwd(sel_m, s1_pos_r.middle, c);
  end

  always_comb begin
    letter_t c;
    c = pass_fwd(sel_l, s2_pos_r.left, s2_let_r);
    c = REFL_TAB[c];
    s3_let_nxt = pass_inv(sel_l, s2_pos_r.left, c);
  end

  always_comb begin
    letter_t c;
    c = pass_inv(sel_m, s3_pos_r.middle, s3_let_r);
    s4_let_pre = pass_inv(sel_r, s3_pos_r.right, c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (go1) begin
        v1_r <= accept && (in_data.command == CMD_ENCIPHER);
      end
      if (go2) begin
        v2_r <= v1_r;
      end
      if (go3) begin
        v3_r <= v2_r;
      end
      if (go4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_pos_r <= pos_step;
      s1_let_r <= s1_let_r_in;
    end
    if (go2) begin
      s2_pos_r <= s1_pos_r;
      s2_let_r <= s2_let_nxt;
    end
    if (go3) begin
      s3_pos_r <= s2_pos_r;
      s3_let_r <= s3_let_nxt;
    end
    if (go4) begin
      out_r.out_letter <= plug_out_let;
      out_r.out_left   <= s3_pos_r.left;
      out_r.out_middle <= s3_pos_r.middle;
      out_r.out_right  <= s3_pos_r.right;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (pos_r.left < NLET && pos_r.middle < NLET && pos_r.right < NLET))
    else $error("rotor position out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_letter < NLET && out_data.out_left < NLET &&
                   out_data.out_middle < NLET && out_data.out_right < NLET))
    else $error("result field out of range");

  a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_LOAD) |=>
      (pos_r.right == $past(mod26(in_data.new_right)) &&
       pos_r.left == $past(mod26(in_data.new_left))))
    else $error("load request did not set the positions");

  a_right_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_ENCIPHER) |=>
      (pos_r.right == inc26($past(pos_r.right))))
    else $error("right rotor failed to step");

endmodule

/* test/tb_three_rotor_cipher_machine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for three_rotor_cipher_machine: a directed table, then randomised
// request phases under changing rotor and plugboard settings, checked by a local predictor.
// Depends on tcm_pkg and the RTL of the block.
module tb_three_rotor_cipher_machine;
  import tcm_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int PIPE_DEPTH    = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 125;
  localparam int TIMEOUT_NS    = 10_000_000;
  localparam cfg_idx_t CFG_SPARE_IDX = 3'd7;

  localparam logic [8*26-1:0] WIRING_I    = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
  localparam logic [8*26-1:0] WIRING_II   = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
  localparam logic [8*26-1:0] WIRING_III  = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
  localparam logic [8*26-1:0] WIRING_IV   = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
  localparam logic [8*26-1:0] WIRING_V    = "VZBRGITYUPSDNHLXAWMJQOFECK";
  localparam logic [8*26-1:0] REFLECTOR_B = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

  typedef struct packed {
    bit         is_write;
    cfg_idx_t   idx;
    plug_word_t val;
    in_req_t    req;
    bit         typed;
    out_res_t   want;
  } stim_row_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_req_t    in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_res_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = '0;
  plug_word_t cfg_data  = '0;

  rotor_num_t rotor_num [3];
  plug_word_t plug_word [3] = '{default: '0};
  letter_t    pos_left   = LETTER_A;
  letter_t    pos_middle = LETTER_A;
  letter_t    pos_right  = LETTER_A;
  cfg_idx_t   rotor_reg [3] = '{CFG_LEFT_ROTOR, CFG_MIDDLE_ROTOR, CFG_RIGHT_ROTOR};
  cfg_idx_t   plug_reg  [3] = '{CFG_PLUG_PAIRS_A, CFG_PLUG_PAIRS_B, CFG_PLUG_PAIRS_C};

  out_res_t   expected_cipher [$];
  stim_row_t  stim_table [$];
  int         errors     = 0;
  int         enciphered = 0;
  int         loads      = 0;
  int         reg_writes = 0;
  int         stall_mode  = 0;
  int         stall_count = 0;

  three_rotor_cipher_machine dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int wheel_of(rotor_num_t n);
    return (n >= 3'd1 && n <= 3'd5) ? int'(n) - 1 : 0;
  endfunction

  function automatic int wiring_at(int wheel, int j);
    logic [8*26-1:0] w;
    case (wheel)
      0: w = WIRING_I;
      1: w = WIRING_II;
      2: w = WIRING_III;
      3: w = WIRING_IV;
      default: w = WIRING_V;
    endcase
    return int'(w[8*(25-j) +: 8]) - 65;
  endfunction

  // Turnover letters Q, E, V, J and Z.
  function automatic int turnover(int wheel);
    case (wheel)
      0: return 16;
      1: return 4;
      2: return 21;
      3: return 9;
      default: return 25;
    endcase
  endfunction

  function automatic int through_wheel(int wheel, int pos, int x, bit reverse);
    int contact;
    int exit_pin;
    contact = (x + pos) % 26;
    exit_pin = 0;
    if (!reverse) begin
      exit_pin = wiring_at(wheel, contact);
    end else begin
      for (int j = 0; j < 26; j++) begin
        if (wiring_at(wheel, j) == contact) begin
          exit_pin = j;
        end
      end
    end
    return (exit_pin + 26 - pos) % 26;
  endfunction

  // Pairs are applied in order, and a pair touching a letter already taken is dropped.
  function automatic int plug_swap(int c);
    bit taken [26];
    int partner [26];
    int a;
    int b;
    for (int k = 0; k < 26; k++) begin
      partner[k] = k;
      taken[k] = 1'b0;
    end
    for (int k = 0; k < 6; k++) begin
      a = int'(plug_word[k/2][10*(k%2) +: 5]);
      b = int'(plug_word[k/2][10*(k%2)+5 +: 5]);
      if (a != b && a < 26 && b < 26) begin
        if (!taken[a] && !taken[b]) begin
          taken[a] = 1'b1;
          taken[b] = 1'b1;
          partner[a] = b;
          partner[b] = a;
        end
      end
    end
    return partner[c];
  endfunction

  function automatic bit machine_step(input in_req_t r, output out_res_t res);
    int  lw;
    int  mw;
    int  rw;
    int  c;
    bit  mid_turn;
    bit  right_turn;
    res = '0;
    if (r.command == CMD_LOAD) begin
      pos_left   = letter_t'(int'(r.new_left) % 26);
      pos_middle = letter_t'(int'(r.new_middle) % 26);
      pos_right  = letter_t'(int'(r.new_right) % 26);
      return 1'b0;
    end
    lw = wheel_of(rotor_num[0]);
    mw = wheel_of(rotor_num[1]);
    rw = wheel_of(rotor_num[2]);
    mid_turn   = int'(pos_middle) == turnover(mw);
    right_turn = int'(pos_right) == turnover(rw);
    if (mid_turn) begin
      pos_left = letter_t'((int'(pos_left) + 1) % 26);
    end
    if (mid_turn || right_turn) begin
      pos_middle = letter_t'((int'(pos_middle) + 1) % 26);
    end
    pos_right = letter_t'((int'(pos_right) + 1) % 26);
    c = plug_swap(int'(r.in_letter) % 26);
    c = through_wheel(rw, int'(pos_right), c, 1'b0);
    c = through_wheel(mw, int'(pos_middle), c, 1'b0);
    c = through_wheel(lw, int'(pos_left), c, 1'b0);
    c = int'(REFLECTOR_B[8*(25-c) +: 8]) - 65;
    c = through_wheel(lw, int'(pos_left), c, 1'b1);
    c = through_wheel(mw, int'(pos_middle), c, 1'b1);
    c = through_wheel(rw, int'(pos_right), c, 1'b1);
    c = plug_swap(c);
    res.out_letter = letter_t'(c);
    res.out_left   = pos_left;
    res.out_middle = pos_middle;
    res.out_right  = pos_right;
    return 1'b1;
  endfunction

  function automatic plug_word_t random_plugs();
    plug_word_t w;
    for (int k = 0; k < 4; k++) begin
      w[5*k +: 5] = ($urandom_range(0, 9) == 0) ? letter_t'($urandom_range(26, 31))
                                                 : letter_t'($urandom_range(0, 25));
    end
    return w;
  endfunction

  function automatic rotor_num_t random_wheel_num();
    if ($urandom_range(0, 7) == 0) begin
      return rotor_num_t'($urandom_range(0, 7));
    end
    return rotor_num_t'($urandom_range(1, 5));
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    r.command = ($urandom_range(0, 11) == 0) ? CMD_LOAD : CMD_ENCIPHER;
    r.in_letter = ($urandom_range(0, 7) == 0) ? letter_t'($urandom_range(26, 31))
                                               : letter_t'($urandom_range(0, 25));
    r.new_left = letter_t'($urandom_range(0, 31));
    if (r.command == CMD_LOAD && $urandom_range(0, 1) == 1) begin
      // Park the middle and right rotors at or just short of their notches to provoke turnovers.
      r.new_middle = letter_t'((turnover(wheel_of(rotor_num[1])) + 26
                                - $urandom_range(0, 1)) % 26);
      r.new_right  = letter_t'((turnover(wheel_of(rotor_num[2])) + 26
                                - $urandom_range(0, 2)) % 26);
    end else begin
      r.new_middle = letter_t'($urandom_range(0, 31));
      r.new_right  = letter_t'($urandom_range(0, 31));
    end
    return r;
  endfunction

  task automatic add_request(logic cmd, letter_t letter, letter_t l, letter_t m, letter_t r);
    stim_row_t row;
    row = '0;
    row.req = '{command: cmd, in_letter: letter, new_left: l, new_middle: m, new_right: r};
    stim_table.push_back(row);
  endtask

  task automatic add_known(letter_t letter, letter_t cipher, letter_t l, letter_t m,
                           letter_t r);
    stim_row_t row;
    row = '0;
    row.req.command = CMD_ENCIPHER;
    row.req.in_letter = letter;
    row.typed = 1'b1;
    row.want = '{out_letter: cipher, out_left: l, out_middle: m, out_right: r};
    stim_table.push_back(row);
  endtask

  task automatic add_write(cfg_idx_t idx, plug_word_t val);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = idx;
    row.val = val;
    stim_table.push_back(row);
  endtask

  task automatic put_req(in_req_t r, bit typed, out_res_t want);
    out_res_t res;
    cfg_valid <= 1'b0;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (machine_step(r, res)) begin
      expected_cipher.push_back(typed ? want : res);
      enciphered++;
    end else begin
      loads++;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, plug_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEFT_ROTOR:   rotor_num[0] = val[2:0];
      CFG_MIDDLE_ROTOR: rotor_num[1] = val[2:0];
      CFG_RIGHT_ROTOR:  rotor_num[2] = val[2:0];
      CFG_PLUG_PAIRS_A: plug_word[0] = val;
      CFG_PLUG_PAIRS_B: plug_word[1] = val;
      CFG_PLUG_PAIRS_C: plug_word[2] = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_cipher.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic pause_input(int cycles);
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic check_field(string name, letter_t want, letter_t got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_count <= $urandom_range(20, 80);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_count % 8) < 5;
    endcase
  end

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cipher.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, out_data);
        errors++;
      end else begin
        want = expected_cipher.pop_front();
        check_field("out_letter", want.out_letter, out_data.out_letter);
        check_field("out_left", want.out_left, out_data.out_left);
        check_field("out_middle", want.out_middle, out_data.out_middle);
        check_field("out_right", want.out_right, out_data.out_right);
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("%0t: timed out with %0d results outstanding", $time, expected_cipher.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t  row;
    rotor_num_t num;
    int         burst;
    rotor_num[0] = LEFT_ROTOR_RST;
    rotor_num[1] = MIDDLE_ROTOR_RST;
    rotor_num[2] = RIGHT_ROTOR_RST;

    // From reset, five As encipher to B D Z G O while the right rotor advances.
    add_known(LETTER_A, 5'd1, LETTER_A, LETTER_A, 5'd1);
    add_known(LETTER_A, 5'd3, LETTER_A, LETTER_A, 5'd2);
    add_known(LETTER_A, LETTER_Z, LETTER_A, LETTER_A, 5'd3);
    add_known(LETTER_A, 5'd6, LETTER_A, LETTER_A, 5'd4);
    add_known(LETTER_A, 5'd14, LETTER_A, LETTER_A, 5'd5);
    // The middle rotor steps twice running as it passes its own notch.
    add_request(CMD_LOAD, 5'd0, LETTER_A, 5'd3, 5'd20);
    add_request(CMD_ENCIPHER, LETTER_Z, 5'd31, 5'd31, 5'd31);
    add_request(CMD_ENCIPHER, LETTER_A, 5'd0, 5'd0, 5'd0);
    add_request(CMD_ENCIPHER, 5'd13, 5'd17, 5'd9, 5'd2);
    add_request(CMD_LOAD, 5'd31, 5'd31, 5'd30, 5'd26);
    add_request(CMD_ENCIPHER, 5'd31, 5'd0, 5'd0, 5'd0);
    add_request(CMD_ENCIPHER, 5'd26, 5'd0, 5'd0, 5'd0);
    add_request(CMD_LOAD, 5'd0, LETTER_Z, LETTER_Z, LETTER_Z);
    add_request(CMD_ENCIPHER, LETTER_Z, 5'd0, 5'd0, 5'd0);
    // Out-of-range wheel numbers, overlapping, equal and out-of-range plug pairs.
    add_write(CFG_LEFT_ROTOR, 20'd0);
    add_write(CFG_MIDDLE_ROTOR, 20'd7);
    add_write(CFG_RIGHT_ROTOR, 20'd6);
    add_write(CFG_PLUG_PAIRS_A, {5'd2, 5'd1, 5'd1, 5'd0});
    add_write(CFG_PLUG_PAIRS_B, {5'd3, 5'd31, 5'd2, 5'd2});
    add_write(CFG_PLUG_PAIRS_C, 20'hFFFFF);
    add_write(CFG_SPARE_IDX, 20'h5A5A5);
    add_request(CMD_LOAD, 5'd0, LETTER_A, 5'd16, 5'd16);
    add_request(CMD_ENCIPHER, 5'd0, 5'd0, 5'd0, 5'd0);
    add_request(CMD_ENCIPHER, 5'd1, 5'd0, 5'd0, 5'd0);
    add_request(CMD_ENCIPHER, 5'd2, 5'd0, 5'd0, 5'd0);
    add_request(CMD_ENCIPHER, 5'd3, 5'd0, 5'd0, 5'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.is_write) begin
        settle();
        write_reg(row.idx, row.val);
      end else begin
        put_req(row.req, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      for (int k = 0; k < 3; k++) begin
        num = (ph == 0) ? rotor_num_t'(5) : (ph == 1) ? rotor_num_t'(1) : random_wheel_num();
        write_reg(rotor_reg[k], plug_word_t'({$urandom, num}));
      end
      for (int k = 0; k < 3; k++) begin
        write_reg(plug_reg[k], (ph == 0) ? plug_word_t'(0) : random_plugs());
      end
      burst = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if ($urandom_range(0, 3) != 0) begin
            pause_input($urandom_range(1, 6));
          end
        end
        burst--;
        put_req(random_req(), 1'b0, '0);
      end
    end

    settle();
    $display("Enciphered %0d letters and loaded positions %0d times over %0d register writes.",
             enciphered, loads, reg_writes);
    if (errors == 0 && expected_cipher.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* three_rotor_cipher_machine.f */
rtl/core/tcm_pkg.sv
rtl/core/tcm_plugboard.sv
rtl/core/three_rotor_cipher_machine.sv
test/tb_three_rotor_cipher_machine.sv
